@@ rtl/ael_pkg.sv @@
// Package for the arithmetic expression lexer: token kinds, character codes
// and the token record type. No dependencies.
`default_nettype none

package ael_pkg;

    localparam int FieldBits = 16;

    typedef enum logic [3:0] {
        KIND_INT     = 4'd0,
        KIND_FLOAT   = 4'd1,
        KIND_NEWLINE = 4'd2,
        KIND_PLUS    = 4'd3,
        KIND_MINUS   = 4'd4,
        KIND_STAR    = 4'd5,
        KIND_SLASH   = 4'd6,
        KIND_LPAREN  = 4'd7,
        KIND_RPAREN  = 4'd8,
        KIND_ERROR   = 4'd9,
        KIND_EOF     = 4'd10
    } kind_t;

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_END  = 1'b1
    } opcode_t;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VTAB    = 8'h0B;
    localparam logic [7:0] CH_FFEED   = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef struct packed {
        kind_t                kind;
        logic [FieldBits-1:0] offset;
        logic [FieldBits-1:0] length;
        logic [FieldBits-1:0] line;
        logic [FieldBits-1:0] column;
        logic                 last;
    } token_t;

endpackage

`default_nettype wire

@@ rtl/arithmetic_expression_lexer.sv @@
// Arithmetic expression lexer top level: scanner state, position counters
// and a four-word token queue. Depends on ael_pkg.
//
// A token word is registered into the token queue when the byte that causes
// it is accepted; m_axis offers the queue head. Throughput: one byte per
// cycle while the sink takes one word per cycle; a byte may cause two words,
// and s_axis_tready drops while more than two words sit in the token queue.
// Reset (aresetn low, synchronous) empties the queue and returns the scanner
// to line 1, column 1, offset 0 outside a number.
`default_nettype none

module arithmetic_expression_lexer
    import ael_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_code[7:0]
    input  wire logic        s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // start_offset[15:0], token_length[31:16], start_line[47:32],
    // start_column[63:48]
    output logic [63:0]      m_axis_tdata,
    output logic [3:0]       m_axis_tuser,   // token_kind[3:0]
    output logic             m_axis_tlast
);

    localparam int PB      = POSITION_BITS;
    localparam int ExtBits = (PB > FieldBits) ? PB : FieldBits;
    localparam int QDepth  = 4;
    localparam int QCntBits = $clog2(QDepth + 1);
    localparam logic [PB-1:0] PosMax = {PB{1'b1}};
    localparam logic [PB-1:0] PosOne = PB'(1);

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
        return (v == PosMax) ? v : v + PosOne;
    endfunction

    function automatic logic [FieldBits-1:0] to_field(input logic [PB-1:0] v);
        logic [ExtBits-1:0] w;
        w = ExtBits'(v);
        return w[FieldBits-1:0];
    endfunction

    // scanner state
    logic          in_number_reg, in_number_next;
    logic          has_dot_reg, has_dot_next;
    logic [PB-1:0] num_offset_reg, num_offset_next;
    logic [PB-1:0] num_line_reg, num_line_next;
    logic [PB-1:0] num_column_reg, num_column_next;
    logic [PB-1:0] num_len_reg, num_len_next;
    logic [PB-1:0] cur_offset_reg, cur_offset_next;
    logic [PB-1:0] cur_line_reg, cur_line_next;
    logic [PB-1:0] cur_column_reg, cur_column_next;

    // token queue, head at slot 0
    token_t                q_reg [QDepth];
    token_t                q_next [QDepth];
    logic [QCntBits-1:0]   count_reg, count_next;

    logic          accept, pop;
    logic [7:0]    c;
    logic          is_end, is_digit, is_space, continues;
    logic          close_num, emit_tok;
    kind_t         char_kind;
    token_t        num_tok, other_tok, first_tok;
    logic [1:0]    n_push;
    logic [QCntBits-1:0] base;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (count_reg <= QCntBits'(QDepth - 2));
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tlast  = q_reg[0].last;
    assign m_axis_tuser  = q_reg[0].kind;
    assign m_axis_tdata  = {q_reg[0].column, q_reg[0].line,
                            q_reg[0].length, q_reg[0].offset};

    assign c         = s_axis_tdata;
    assign is_end    = (opcode_t'(s_axis_tuser) == OP_END);
    assign is_digit  = (c inside {[CH_ZERO:CH_NINE]});
    assign is_space  = (c inside {CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED, CH_CR});
    assign continues = in_number_reg && !is_end
                       && (is_digit || c == CH_UNDER || (c == CH_DOT && !has_dot_reg));
    assign close_num = in_number_reg && !continues;
    assign emit_tok  = is_end || (!continues && !is_space && !is_digit);

    always_comb begin
        case (c)
            CH_NEWLINE: char_kind = KIND_NEWLINE;
            CH_PLUS:    char_kind = KIND_PLUS;
            CH_MINUS:   char_kind = KIND_MINUS;
            CH_STAR:    char_kind = KIND_STAR;
            CH_SLASH:   char_kind = KIND_SLASH;
            CH_LPAREN:  char_kind = KIND_LPAREN;
            CH_RPAREN:  char_kind = KIND_RPAREN;
            default:    char_kind = KIND_ERROR;
        endcase
    end

    always_comb begin
        num_tok.kind   = has_dot_reg ? KIND_FLOAT : KIND_INT;
        num_tok.offset = to_field(num_offset_reg);
        num_tok.length = to_field(num_len_reg);
        num_tok.line   = to_field(num_line_reg);
        num_tok.column = to_field(num_column_reg);
        num_tok.last   = !emit_tok;

        other_tok.kind   = is_end ? KIND_EOF : char_kind;
        other_tok.offset = to_field(cur_offset_reg);
        other_tok.length = is_end ? '0 : FieldBits'(1);
        other_tok.line   = to_field(cur_line_reg);
        other_tok.column = to_field(cur_column_reg);
        other_tok.last   = 1'b1;

        first_tok = close_num ? num_tok : other_tok;
        n_push    = accept ? (2'(close_num) + 2'(emit_tok)) : 2'd0;
    end

    // scanner next state
    always_comb begin
        in_number_next  = in_number_reg;
        has_dot_next    = has_dot_reg;
        num_offset_next = num_offset_reg;
        num_line_next   = num_line_reg;
        num_column_next = num_column_reg;
        num_len_next    = num_len_reg;
        cur_offset_next = cur_offset_reg;
        cur_line_next   = cur_line_reg;
        cur_column_next = cur_column_reg;
        if (accept) begin
            if (close_num) begin
                in_number_next = 1'b0;
                has_dot_next   = 1'b0;
            end
            if (!is_end) begin
                cur_offset_next = sat_inc(cur_offset_reg);
                if (c == CH_NEWLINE) begin
                    cur_line_next   = sat_inc(cur_line_reg);
                    cur_column_next = PosOne;
                end else begin
                    cur_column_next = sat_inc(cur_column_reg);
                end
                if (continues) begin
                    if (c == CH_DOT) begin
                        has_dot_next = 1'b1;
                    end
                    num_len_next = sat_inc(num_len_reg);
                end else if (is_digit) begin
                    in_number_next  = 1'b1;
                    has_dot_next    = 1'b0;
                    num_offset_next = cur_offset_reg;
                    num_line_next   = cur_line_reg;
                    num_column_next = cur_column_reg;
                    num_len_next    = PosOne;
                end
            end
        end
    end

    // queue next state: shift on pop, append up to two words
    always_comb begin
        base = count_reg - QCntBits'(pop);
        for (int i = 0; i < QDepth - 1; i++) begin
            q_next[i] = pop ? q_reg[i+1] : q_reg[i];
        end
        q_next[QDepth-1] = q_reg[QDepth-1];
        for (int i = 0; i < QDepth; i++) begin
            if (n_push != 2'd0 && base == QCntBits'(i)) begin
                q_next[i] = first_tok;
            end
            if (n_push == 2'd2 && base + QCntBits'(1) == QCntBits'(i)) begin
                q_next[i] = other_tok;
            end
        end
        count_next = base + QCntBits'(n_push);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_number_reg  <= 1'b0;
            has_dot_reg    <= 1'b0;
            num_offset_reg <= '0;
            num_line_reg   <= PosOne;
            num_column_reg <= PosOne;
            num_len_reg    <= '0;
            cur_offset_reg <= '0;
            cur_line_reg   <= PosOne;
            cur_column_reg <= PosOne;
            count_reg      <= '0;
        end else begin
            in_number_reg  <= in_number_next;
            has_dot_reg    <= has_dot_next;
            num_offset_reg <= num_offset_next;
            num_line_reg   <= num_line_next;
            num_column_reg <= num_column_next;
            num_len_reg    <= num_len_next;
            cur_offset_reg <= cur_offset_next;
            cur_line_reg   <= cur_line_next;
            cur_column_reg <= cur_column_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDepth; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

`default_nettype wire
